@@ src/mpct_pkg.sv @@
// Shared types and constants for the mouse packet cursor tracker.
`timescale 1ns / 1ps

package mpct_pkg;

  // Command kinds carried on the result channel.
  localparam logic [1:0] KIND_ERASE  = 2'd0;
  localparam logic [1:0] KIND_DRAW   = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_DISPLAY_PRESENT = 2'd0;
  localparam logic [1:0] REG_SCREEN_WIDTH    = 2'd1;
  localparam logic [1:0] REG_SCREEN_HEIGHT   = 2'd2;

  // Button bits of the first packet byte.
  localparam int BTN_LEFT   = 0;
  localparam int BTN_RIGHT  = 1;
  localparam int BTN_MIDDLE = 2;

  localparam logic [11:0] COORD_MAX       = 12'd4095;
  localparam logic [5:0]  SIZE_MIN        = 6'd10;
  localparam logic [5:0]  SIZE_MAX        = 6'd50;
  localparam logic [5:0]  SIZE_STEP       = 6'd10;
  localparam logic [8:0]  COLOUR_NONE     = 9'd0;
  localparam logic [8:0]  COLOUR_PRESSED  = 9'd100;
  localparam logic [8:0]  COLOUR_RELEASED = 9'd500;

  // One complete mouse packet as queued between front and back.
  typedef struct packed {
    logic [2:0] buttons;
    logic [7:0] dx;
    logic [7:0] dy;
  } packet_t;

  // Configuration as seen by the back end.
  typedef struct packed {
    logic        display_present;
    logic [11:0] screen_width;
    logic [11:0] screen_height;
  } config_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  command_kind;
    logic [11:0] corner_x;
    logic [11:0] corner_y;
    logic [5:0]  square_size;
    logic [8:0]  fill_colour;
    logic        last_of_run;
  } result_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CLAMP,
    B_ERASE,
    B_DRAW,
    B_REPORT
  } back_state_t;

endpackage

@@ src/mpct_front.sv @@
// Front end: assembles incoming mouse bytes into three-byte packets.
`timescale 1ns / 1ps

module mpct_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 queue_full,
  output logic                 push,
  output mpct_pkg::packet_t    push_packet
);
  import mpct_pkg::*;

  localparam logic [1:0] POS_BUTTONS = 2'd0;
  localparam logic [1:0] POS_DX      = 2'd1;
  localparam logic [1:0] POS_DY      = 2'd2;

  logic [1:0] byte_position;
  logic [2:0] button_bits;
  logic [7:0] delta_x_byte;
  logic       accept;

  // Only the closing byte of a packet needs room in the queue.
  assign in_ready = (byte_position != POS_DY) || !queue_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (byte_position == POS_DY);

  assign push_packet.buttons = button_bits;
  assign push_packet.dx      = delta_x_byte;
  assign push_packet.dy      = in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_BUTTONS;
      button_bits   <= 3'd0;
      delta_x_byte  <= 8'd0;
    end else if (accept) begin
      case (byte_position)
        POS_BUTTONS: begin
          button_bits   <= in_byte[2:0];
          byte_position <= POS_DX;
        end
        POS_DX: begin
          delta_x_byte  <= in_byte;
          byte_position <= POS_DY;
        end
        default: begin
          byte_position <= POS_BUTTONS;
        end
      endcase
    end
  end

endmodule

@@ src/mpct_queue.sv @@
// Short packet queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module mpct_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mpct_pkg::packet_t push_packet,
  input  logic              pop,
  output mpct_pkg::packet_t pop_packet,
  output logic              full,
  output logic              empty
);
  import mpct_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  packet_t          entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_FULL);
  assign empty      = (count == '0);
  assign pop_packet = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_packet;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/mpct_back.sv @@
// Back end: moves the cursor for each packet and issues the draw commands.
`timescale 1ns / 1ps

module mpct_back (
  input  logic              clk,
  input  logic              rst,
  input  mpct_pkg::config_t cfg,
  input  logic              queue_empty,
  input  mpct_pkg::packet_t pop_packet,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output mpct_pkg::result_t out_result
);
  import mpct_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [2:0]  pkt_buttons;
  logic [12:0] move_x;
  logic [12:0] move_y;
  logic [11:0] old_x;
  logic [11:0] old_y;
  logic [5:0]  old_size;
  logic [11:0] cursor_x;
  logic [11:0] cursor_y;
  logic [5:0]  cursor_size;

  logic        slot_free;
  logic        load;

  logic signed [13:0] sum_x;
  logic signed [13:0] sum_y;
  logic [13:0]        reach_x;
  logic [13:0]        reach_y;
  logic signed [13:0] room_x;
  logic signed [13:0] room_y;
  logic [11:0]        sat_x;
  logic [11:0]        sat_y;
  logic [11:0]        fit_x;
  logic [11:0]        fit_y;
  logic [6:0]         size_dn;
  logic [6:0]         size_up;
  logic [5:0]         size_new;

  assign slot_free = !out_valid || out_ready;

  // Raw move, floored at zero.
  assign sum_x = $signed({2'b00, cursor_x}) + 14'(signed'(pop_packet.dx));
  assign sum_y = $signed({2'b00, cursor_y}) - 14'(signed'(pop_packet.dy));

  // Edge fit against the old square size.
  assign reach_x = {1'b0, move_x} + {8'd0, cursor_size};
  assign reach_y = {1'b0, move_y} + {8'd0, cursor_size};
  assign room_x  = $signed({2'b00, cfg.screen_width})  - $signed({8'd0, cursor_size});
  assign room_y  = $signed({2'b00, cfg.screen_height}) - $signed({8'd0, cursor_size});
  assign sat_x   = move_x[12] ? COORD_MAX : move_x[11:0];
  assign sat_y   = move_y[12] ? COORD_MAX : move_y[11:0];

  always_comb begin
    if (reach_x > {2'b00, cfg.screen_width}) begin
      fit_x = room_x[13] ? 12'd0 : room_x[11:0];
    end else begin
      fit_x = sat_x;
    end
    if (reach_y > {2'b00, cfg.screen_height}) begin
      fit_y = room_y[13] ? 12'd0 : room_y[11:0];
    end else begin
      fit_y = sat_y;
    end
  end

  // Right shrinks, otherwise middle grows, within the size limits.
  assign size_dn = {1'b0, cursor_size} - {1'b0, SIZE_STEP};
  assign size_up = {1'b0, cursor_size} + {1'b0, SIZE_STEP};
  always_comb begin
    if (pkt_buttons[BTN_RIGHT]) begin
      size_new = (size_dn[6] || size_dn < {1'b0, SIZE_MIN}) ? SIZE_MIN : size_dn[5:0];
    end else if (pkt_buttons[BTN_MIDDLE]) begin
      size_new = (size_up > {1'b0, SIZE_MAX}) ? SIZE_MAX : size_up[5:0];
    end else begin
      size_new = cursor_size;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!queue_empty) state_next = B_CLAMP;
      end
      B_CLAMP: begin
        if (!cfg.display_present)        state_next = B_REPORT;
        else if (!pkt_buttons[BTN_LEFT]) state_next = B_ERASE;
        else                             state_next = B_DRAW;
      end
      B_ERASE: begin
        if (slot_free) state_next = B_DRAW;
      end
      B_DRAW, B_REPORT: begin
        if (slot_free) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    load = 1'b0;
    unique case (state)
      B_IDLE:                    pop  = !queue_empty;
      B_CLAMP:                   ;
      B_ERASE, B_DRAW, B_REPORT: load = slot_free;
      default:                   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pkt_buttons <= pop_packet.buttons;
      move_x      <= sum_x[13] ? 13'd0 : sum_x[12:0];
      move_y      <= sum_y[13] ? 13'd0 : sum_y[12:0];
      old_x       <= cursor_x;
      old_y       <= cursor_y;
    end
    if (state == B_CLAMP) begin
      old_size <= cursor_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x    <= 12'd0;
      cursor_y    <= 12'd0;
      cursor_size <= SIZE_MIN;
    end else if (state == B_CLAMP) begin
      if (cfg.display_present) begin
        cursor_x    <= fit_x;
        cursor_y    <= fit_y;
        cursor_size <= size_new;
      end else begin
        cursor_x <= sat_x;
        cursor_y <= sat_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      case (state)
        B_ERASE: begin
          out_result.command_kind <= KIND_ERASE;
          out_result.corner_x     <= old_x;
          out_result.corner_y     <= old_y;
          out_result.square_size  <= old_size;
          out_result.fill_colour  <= COLOUR_NONE;
          out_result.last_of_run  <= 1'b0;
        end
        B_DRAW: begin
          out_result.command_kind <= KIND_DRAW;
          out_result.corner_x     <= cursor_x;
          out_result.corner_y     <= cursor_y;
          out_result.square_size  <= cursor_size;
          out_result.fill_colour  <= pkt_buttons[BTN_LEFT] ? COLOUR_PRESSED
                                                           : COLOUR_RELEASED;
          out_result.last_of_run  <= 1'b1;
        end
        default: begin
          out_result.command_kind <= KIND_REPORT;
          out_result.corner_x     <= cursor_x;
          out_result.corner_y     <= cursor_y;
          out_result.square_size  <= cursor_size;
          out_result.fill_colour  <= COLOUR_NONE;
          out_result.last_of_run  <= 1'b1;
        end
      endcase
    end
  end

endmodule

@@ src/mouse_packet_cursor_tracker_unit.sv @@
// Top level of the mouse packet cursor tracker.
`timescale 1ns / 1ps

// Mouse bytes enter one beat at a time on the slave stream and are grouped
// into three-byte packets (buttons, signed dx, signed dy). A byte is taken
// in every cycle; only the third byte of a packet waits, and only when the
// packet queue is full. Each packet then goes through the back end, which
// fetches it and applies the move, then fits the square to the screen and
// updates the size, then loads each result beat into its output register
// when that register is free. The back end can take the next packet only
// after the last beat of the current one is loaded, so the master side can
// stall it. Bytes are taken at one per cycle until the queue fills; after
// that the slave side waits on the back end as it pops packets.
// With a display present the block emits an erase beat for the old square
// (only when the left button is up) and then a draw beat for the new one;
// without a display it emits a single position report. The draw beat and
// the report carry tlast. Configuration registers are written through the
// plain write port, and the user must write them only while the block is
// idle (not enforced by the block); writes to unused indexes are ignored.
module mouse_packet_cursor_tracker_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // Slave stream: tdata holds packet_byte[7:0].
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  // Master stream: tdata holds corner_x[11:0], corner_y[23:12],
  // square_size[29:24], fill_colour[38:30], zero fill [39].
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  // tuser holds command_kind[1:0].
  output logic [1:0]  m_tuser,
  // tlast holds last_of_run.
  output logic        m_tlast,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import mpct_pkg::*;

  config_t cfg;
  packet_t push_packet;
  packet_t pop_packet;
  result_t result;
  logic    push;
  logic    pop;
  logic    queue_full;
  logic    queue_empty;

  // Configuration registers; the back end reads them when it fits each packet.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.display_present <= 1'b1;
      cfg.screen_width    <= 12'd640;
      cfg.screen_height   <= 12'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISPLAY_PRESENT: cfg.display_present <= cfg_data[0];
        REG_SCREEN_WIDTH:    cfg.screen_width    <= cfg_data;
        REG_SCREEN_HEIGHT:   cfg.screen_height   <= cfg_data;
        default:             ;
      endcase
    end
  end

  // Front end collects bytes and hands complete packets to the queue.
  mpct_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_byte     (s_tdata),
    .queue_full  (queue_full),
    .push        (push),
    .push_packet (push_packet)
  );

  mpct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_packet (push_packet),
    .pop         (pop),
    .pop_packet  (pop_packet),
    .full        (queue_full),
    .empty       (queue_empty)
  );

  // Back end owns the cursor state and the result register.
  mpct_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .queue_empty (queue_empty),
    .pop_packet  (pop_packet),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_result  (result)
  );

  assign m_tdata = {1'b0, result.fill_colour, result.square_size,
                    result.corner_y, result.corner_x};
  assign m_tuser = result.command_kind;
  assign m_tlast = result.last_of_run;

endmodule
